### rtl/gzrc_pkg.sv
// Shared types and constants for the gyro zero-rate calibration block.
// No dependencies.
package gzrc_pkg;

	localparam int SAMPLE_W = 16;

	// func field codes
	localparam logic FUNC_SAMPLE  = 1'b0;
	localparam logic FUNC_RESTART = 1'b1;

	// per-axis controls issued by the sequencer for one accepted transaction
	typedef struct packed {
		logic clear;   // restart: zero sum and limit
		logic accum;   // calibration sample: add to sum, track max
		logic latch;   // last calibration sample: load offset from new sum
	} axis_ctrl_t;

endpackage

### rtl/gzrc_intf.sv
// Valid/ready channel interfaces for samples in and corrected rates out.
// Depends on gzrc_pkg.
interface gzrc_in_if import gzrc_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic                       func;
	logic signed [SAMPLE_W-1:0] x_sample;
	logic signed [SAMPLE_W-1:0] y_sample;
	logic signed [SAMPLE_W-1:0] z_sample;

	modport source (output valid, func, x_sample, y_sample, z_sample, input ready);
	modport sink   (input valid, func, x_sample, y_sample, z_sample, output ready);
endinterface

interface gzrc_out_if import gzrc_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] x_rate;
	logic signed [SAMPLE_W-1:0] y_rate;
	logic signed [SAMPLE_W-1:0] z_rate;

	modport source (output valid, x_rate, y_rate, z_rate, input ready);
	modport sink   (input valid, x_rate, y_rate, z_rate, output ready);
endinterface

### rtl/gzrc_axis.sv
// One axis: calibration sum, running max, offset and dead-band correction.
// Depends on gzrc_pkg.
module gzrc_axis import gzrc_pkg::*; #(
	parameter int CAL_LOG2 = 7
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  axis_ctrl_t                 ctrl,
	input  logic signed [SAMPLE_W-1:0] sample,
	output logic signed [SAMPLE_W-1:0] rate
);

	localparam int SUM_W = SAMPLE_W + CAL_LOG2;
	localparam int LIM_W = SAMPLE_W - 1;

	logic signed [SUM_W-1:0]    sum_q;
	logic signed [SUM_W-1:0]    sum_nxt;
	logic        [LIM_W-1:0]    limit_q;
	logic signed [SAMPLE_W-1:0] offset_q;
	logic signed [SAMPLE_W:0]   diff;
	logic signed [SAMPLE_W-1:0] sat;
	logic        [SAMPLE_W:0]   mag;
	logic                       raise;

	assign sum_nxt = sum_q + SUM_W'(sample);
	assign raise   = sample > $signed({1'b0, limit_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			limit_q  <= '0;
			offset_q <= '0;
		end else if (ctrl.clear) begin
			sum_q   <= '0;
			limit_q <= '0;
		end else if (ctrl.accum) begin
			sum_q <= sum_nxt;
			if (raise)
				limit_q <= sample[LIM_W-1:0];
			// floor average of 16-bit samples always fits 16 bits
			if (ctrl.latch)
				offset_q <= sum_nxt[SUM_W-1:CAL_LOG2];
		end
	end

	assign diff = {sample[SAMPLE_W-1], sample} - {offset_q[SAMPLE_W-1], offset_q};

	always_comb begin
		if (diff[SAMPLE_W] != diff[SAMPLE_W-1])
			sat = diff[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
		else
			sat = diff[SAMPLE_W-1:0];
		mag = sat[SAMPLE_W-1] ? -{1'b1, sat} : {1'b0, sat};
		// -32768 gives magnitude 32768, above any limit
		rate = (mag < {2'b00, limit_q}) ? '0 : sat;
	end

endmodule

### rtl/gyro_zero_rate_calibrate_deadzone.sv
// Top level of the gyro zero-rate calibration and dead-band block.
// Depends on gzrc_pkg, gzrc_in_if, gzrc_out_if and gzrc_axis.
//
//   channel     dir   payload                          when
//   sample_in   in    func, x/y/z_sample (s16)         every sample or restart
//   rate_out    out   x/y/z_rate (s16)                 one per corrected sample
//
// One transaction per cycle while sample_in.ready is high: the axis sums,
// limits and the correction are one adder, one compare and one subtract per
// axis between port and output register; rate_out.valid is set the next cycle.
// Reset (arst_n low) clears sums, limits, offsets and count; the first
// 2^CAL_LOG2 samples then calibrate and produce no transaction, as do restarts.
// sample_in.ready drops only while a result sits unaccepted and rate_out.ready
// is low; the output register takes a new result as the old one leaves.
module gyro_zero_rate_calibrate_deadzone import gzrc_pkg::*; #(
	parameter int CAL_LOG2 = 7
) (
	input  logic clk,
	input  logic arst_n,
	gzrc_in_if.sink    sample_in,
	gzrc_out_if.source rate_out
);

	// calibration sample counter; wraps to zero on the last sample
	logic [CAL_LOG2-1:0] cal_count_q;
	logic                calibrated_q;

	logic       accept;
	logic       last_cal;
	logic       emit;
	axis_ctrl_t ctrl;

	logic signed [SAMPLE_W-1:0] x_corr, y_corr, z_corr;

	// output register
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] x_rate_q, y_rate_q, z_rate_q;

	assign sample_in.ready = !out_valid_q || rate_out.ready;
	assign accept          = sample_in.valid && sample_in.ready;
	assign last_cal        = cal_count_q == {CAL_LOG2{1'b1}};

	always_comb begin
		ctrl  = '0;
		emit  = 1'b0;
		if (accept) begin
			if (sample_in.func == FUNC_RESTART) begin
				ctrl.clear = 1'b1;
			end else if (!calibrated_q) begin
				ctrl.accum = 1'b1;
				ctrl.latch = last_cal;
			end else begin
				emit = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_count_q  <= '0;
			calibrated_q <= 1'b0;
		end else if (ctrl.clear) begin
			cal_count_q  <= '0;
			calibrated_q <= 1'b0;
		end else if (ctrl.accum) begin
			cal_count_q <= cal_count_q + 1'b1;
			if (last_cal)
				calibrated_q <= 1'b1;
		end
	end

	gzrc_axis #(.CAL_LOG2(CAL_LOG2)) u_axis_x (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.sample (sample_in.x_sample),
		.rate   (x_corr)
	);

	gzrc_axis #(.CAL_LOG2(CAL_LOG2)) u_axis_y (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.sample (sample_in.y_sample),
		.rate   (y_corr)
	);

	gzrc_axis #(.CAL_LOG2(CAL_LOG2)) u_axis_z (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.sample (sample_in.z_sample),
		.rate   (z_corr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (rate_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			x_rate_q <= x_corr;
			y_rate_q <= y_corr;
			z_rate_q <= z_corr;
		end
	end

	assign rate_out.valid  = out_valid_q;
	assign rate_out.x_rate = x_rate_q;
	assign rate_out.y_rate = y_rate_q;
	assign rate_out.z_rate = z_rate_q;

endmodule
